// ===== src/tlc_pkg.sv =====
// Shared constants and helpers for the two-level cache tag controller.
package tlc_pkg;

    localparam int DEF_FIRST_SETS   = 128;
    localparam int DEF_FIRST_WAYS   = 8;
    localparam int DEF_SECOND_SETS  = 4096;
    localparam int DEF_SECOND_WAYS  = 16;
    localparam int DEF_LINE_BYTES   = 64;
    localparam int DEF_ADDRESS_BITS = 27;

    localparam int SEED_W   = 16;
    localparam int FWAY_W   = 3;
    localparam int SWAY_W   = 4;
    localparam int VLINE_W  = 21;
    localparam int M_DATA_W = 40;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'd1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] n;
        n = v >> 1;
        if (v[0]) begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    function automatic logic [SEED_W-1:0] seed_value(input logic [SEED_W-1:0] s);
        return (s == '0) ? SEED_RESET : s;
    endfunction

endpackage

// ===== src/two_level_cache_tag_controller.sv =====
// Top level: access queue in front of the two-level tag lookup and update engine.
// Each access moves from a queue entry to the lookup registers, then to the result register.
// Accesses go one at a time: the tag RAMs are read in the idle state and written in evaluate.
// Reset: clears control state and the LFSR to seed 1, then sweeps both tag RAMs,
// max(FIRST_SETS, SECOND_SETS) rows, before the first access enters the lookup.
module two_level_cache_tag_controller #(
    parameter int FIRST_SETS   = tlc_pkg::DEF_FIRST_SETS,
    parameter int FIRST_WAYS   = tlc_pkg::DEF_FIRST_WAYS,
    parameter int SECOND_SETS  = tlc_pkg::DEF_SECOND_SETS,
    parameter int SECOND_WAYS  = tlc_pkg::DEF_SECOND_WAYS,
    parameter int LINE_BYTES   = tlc_pkg::DEF_LINE_BYTES,
    parameter int ADDRESS_BITS = tlc_pkg::DEF_ADDRESS_BITS,
    parameter int S_DATA_W     = ((1 + ADDRESS_BITS + 7) / 8) * 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         victim_seed_we,
    input  logic [tlc_pkg::SEED_W-1:0]   victim_seed_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // op, address
    input  logic [S_DATA_W-1:0]          s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // first_hit, first_way, first_filled, second_hit, second_way, refill,
    // victim_writeback, victim_line, memory_write
    output logic [tlc_pkg::M_DATA_W-1:0] m_tdata
);
    import tlc_pkg::*;

    localparam int LINE_W = ADDRESS_BITS - $clog2(LINE_BYTES);

    logic              q_valid, q_pop, q_op;
    logic [LINE_W-1:0] q_line;

    tlc_front #(
        .LINE_BYTES(LINE_BYTES), .ADDRESS_BITS(ADDRESS_BITS),
        .S_DATA_W(S_DATA_W), .LINE_W(LINE_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_line(q_line)
    );

    tlc_back #(
        .FIRST_SETS(FIRST_SETS), .FIRST_WAYS(FIRST_WAYS),
        .SECOND_SETS(SECOND_SETS), .SECOND_WAYS(SECOND_WAYS), .LINE_W(LINE_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .victim_seed_we(victim_seed_we), .victim_seed_wdata(victim_seed_wdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_op(q_op), .q_line(q_line),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );
endmodule

// ===== src/tlc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/tlc_front.sv =====
// Input side: accept accesses, extract the line address, and queue them.
module tlc_front #(
    parameter int LINE_BYTES   = tlc_pkg::DEF_LINE_BYTES,
    parameter int ADDRESS_BITS = tlc_pkg::DEF_ADDRESS_BITS,
    parameter int S_DATA_W     = ((1 + ADDRESS_BITS + 7) / 8) * 8,
    parameter int LINE_W       = ADDRESS_BITS - $clog2(LINE_BYTES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                q_valid,
    input  logic                q_pop,
    output logic                q_op,
    output logic [LINE_W-1:0]   q_line
);
    localparam int OFF_W = $clog2(LINE_BYTES);
    localparam int ENT_W = 1 + LINE_W;

    logic [ENT_W-1:0] entry_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic [ENT_W-1:0] in_entry;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign in_entry = {s_tdata[ADDRESS_BITS:1+OFF_W], s_tdata[0]};
    assign q_op     = entry_reg[rptr_reg][0];
    assign q_line   = entry_reg[rptr_reg][ENT_W-1:1];

    always_comb begin
        wptr_next  = wptr_reg ^ push;
        rptr_next  = rptr_reg ^ q_pop;
        count_next = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
        if (push) begin
            entry_reg[wptr_reg] <= in_entry;
        end
    end
endmodule

// ===== src/tlc_back.sv =====
// Execution side: tag lookup, replacement, tag update and result register.
module tlc_back #(
    parameter int FIRST_SETS   = tlc_pkg::DEF_FIRST_SETS,
    parameter int FIRST_WAYS   = tlc_pkg::DEF_FIRST_WAYS,
    parameter int SECOND_SETS  = tlc_pkg::DEF_SECOND_SETS,
    parameter int SECOND_WAYS  = tlc_pkg::DEF_SECOND_WAYS,
    parameter int LINE_W       = 21
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            victim_seed_we,
    input  logic [tlc_pkg::SEED_W-1:0]      victim_seed_wdata,
    input  logic                            q_valid,
    output logic                            q_pop,
    input  logic                            q_op,
    input  logic [LINE_W-1:0]               q_line,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tlc_pkg::M_DATA_W-1:0]    m_tdata
);
    import tlc_pkg::*;

    localparam int S1W  = $clog2(FIRST_SETS);
    localparam int S2W  = $clog2(SECOND_SETS);
    localparam int T1W  = LINE_W - S1W;
    localparam int T2W  = LINE_W - S2W;
    localparam int W1B  = (FIRST_WAYS > 1) ? $clog2(FIRST_WAYS) : 1;
    localparam int W2B  = (SECOND_WAYS > 1) ? $clog2(SECOND_WAYS) : 1;
    localparam int E1   = 1 + T1W;
    localparam int E2   = 2 + T2W;
    localparam int R1W  = FIRST_WAYS * E1;
    localparam int R2W  = SECOND_WAYS * E2;
    localparam int CLR_DEPTH = (FIRST_SETS > SECOND_SETS) ? FIRST_SETS : SECOND_SETS;
    localparam int CW   = $clog2(CLR_DEPTH);
    localparam longint unsigned RECIP1 = ((64'd1 << 32) + FIRST_WAYS - 1) / FIRST_WAYS;
    localparam longint unsigned RECIP2 = ((64'd1 << 32) + SECOND_WAYS - 1) / SECOND_WAYS;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CW-1:0]     clr_reg, clr_next;
    logic [SEED_W-1:0] lfsr_reg, lfsr_next;
    logic              op_reg;
    logic [LINE_W-1:0] line_reg;
    logic              out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg;

    logic [S1W-1:0] raddr1, waddr1;
    logic [S2W-1:0] raddr2, waddr2;
    logic [R1W-1:0] rdata1, wdata1;
    logic [R2W-1:0] rdata2, wdata2;
    logic           we1, we2, go;

    logic [S1W-1:0] s1;
    logic [T1W-1:0] t1;
    logic [S2W-1:0] s2;
    logic [T2W-1:0] t2;

    logic               f_hit, f_fill, any_inv1, need2;
    logic [W1B-1:0]     f_way, inv1_way, rnd1;
    logic               s_hit, any_inv2, wb;
    logic [W2B-1:0]     s_way, hit2_way, inv2_way, rnd2;
    logic [SEED_W-1:0]  lfsr_a, lfsr_b, step_a, step_b;
    logic [63:0]        prod1, prod2;
    logic [SEED_W-1:0]  quo1, quo2;
    logic [SEED_W-1:0]  rem1, rem2;
    logic [LINE_W-1:0]  vline;
    logic [R1W-1:0]     new_row1;
    logic [R2W-1:0]     new_row2;

    tlc_ram #(.WIDTH(R1W), .DEPTH(FIRST_SETS)) u_first_tags (
        .aclk(aclk), .we(we1), .waddr(waddr1), .wdata(wdata1),
        .raddr(raddr1), .rdata(rdata1)
    );

    tlc_ram #(.WIDTH(R2W), .DEPTH(SECOND_SETS)) u_second_tags (
        .aclk(aclk), .we(we2), .waddr(waddr2), .wdata(wdata2),
        .raddr(raddr2), .rdata(rdata2)
    );

    assign s1 = line_reg[S1W-1:0];
    assign t1 = line_reg[LINE_W-1:S1W];
    assign s2 = line_reg[S2W-1:0];
    assign t2 = line_reg[LINE_W-1:S2W];

    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign raddr1 = (state_reg == ST_IDLE) ? q_line[S1W-1:0] : s1;
    assign raddr2 = (state_reg == ST_IDLE) ? q_line[S2W-1:0] : s2;
    assign go     = (state_reg == ST_EVAL) && (!out_valid_reg || m_tready);

    always_comb begin
        f_hit    = 1'b0;
        f_way    = '0;
        any_inv1 = 1'b0;
        inv1_way = '0;
        for (int w = FIRST_WAYS - 1; w >= 0; w--) begin
            if (rdata1[w*E1] && rdata1[w*E1+1 +: T1W] == t1) begin
                f_hit = 1'b1;
                f_way = W1B'(w);
            end
            if (!rdata1[w*E1]) begin
                any_inv1 = 1'b1;
                inv1_way = W1B'(w);
            end
        end

        step_a = lfsr_step(lfsr_reg);
        prod1  = 64'(step_a) * RECIP1;
        quo1   = prod1[32 +: SEED_W];
        rem1   = step_a - SEED_W'(32'(quo1) * FIRST_WAYS);
        rnd1   = W1B'(rem1);

        f_fill = (op_reg == OP_READ) && !f_hit;
        lfsr_a = (f_fill && !any_inv1) ? step_a : lfsr_reg;
        if (f_fill) begin
            f_way = any_inv1 ? inv1_way : rnd1;
        end
        need2 = (op_reg == OP_WRITE) || !f_hit;

        new_row1 = rdata1;
        for (int w = 0; w < FIRST_WAYS; w++) begin
            if (W1B'(w) == f_way) begin
                new_row1[w*E1 +: E1] = {t1, 1'b1};
            end
        end

        s_hit    = 1'b0;
        hit2_way = '0;
        any_inv2 = 1'b0;
        inv2_way = '0;
        for (int w = SECOND_WAYS - 1; w >= 0; w--) begin
            if (rdata2[w*E2] && rdata2[w*E2+2 +: T2W] == t2) begin
                s_hit    = 1'b1;
                hit2_way = W2B'(w);
            end
            if (!rdata2[w*E2]) begin
                any_inv2 = 1'b1;
                inv2_way = W2B'(w);
            end
        end

        step_b = lfsr_step(lfsr_a);
        prod2  = 64'(step_b) * RECIP2;
        quo2   = prod2[32 +: SEED_W];
        rem2   = step_b - SEED_W'(32'(quo2) * SECOND_WAYS);
        rnd2   = W2B'(rem2);

        lfsr_b = lfsr_a;
        wb     = 1'b0;
        vline  = '0;
        s_way  = '0;
        if (need2) begin
            if (s_hit) begin
                s_way = hit2_way;
            end else if (any_inv2) begin
                s_way = inv2_way;
            end else begin
                s_way  = rnd2;
                lfsr_b = step_b;
            end
        end

        new_row2 = rdata2;
        for (int w = 0; w < SECOND_WAYS; w++) begin
            if (W2B'(w) == s_way) begin
                if (need2 && !s_hit && !any_inv2 && rdata2[w*E2+1]) begin
                    wb    = 1'b1;
                    vline = {rdata2[w*E2+2 +: T2W], s2};
                end
                if (!s_hit) begin
                    new_row2[w*E2 +: E2] = {t2, 1'b0, 1'b1};
                end
                if (op_reg == OP_WRITE) begin
                    new_row2[w*E2+1] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        lfsr_next      = lfsr_reg;
        out_valid_next = out_valid_reg;
        we1            = 1'b0;
        we2            = 1'b0;
        waddr1         = s1;
        waddr2         = s2;
        wdata1         = new_row1;
        wdata2         = new_row2;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                we1      = 1'b1;
                we2      = 1'b1;
                waddr1   = clr_reg[S1W-1:0];
                waddr2   = clr_reg[S2W-1:0];
                wdata1   = '0;
                wdata2   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CLR_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (go) begin
                    we1            = f_fill;
                    we2            = need2;
                    lfsr_next      = lfsr_b;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (victim_seed_we) begin
            lfsr_next = seed_value(victim_seed_wdata);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            lfsr_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
        end
        if (q_pop) begin
            op_reg   <= q_op;
            line_reg <= q_line;
        end
        if (go) begin
            out_data_reg <= {6'd0,
                             (op_reg == OP_WRITE) && f_hit,
                             VLINE_W'(32'(vline)),
                             wb,
                             need2 && !s_hit,
                             SWAY_W'(32'(s_way)),
                             need2 && s_hit,
                             f_fill,
                             FWAY_W'(32'(f_way)),
                             f_hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule
